// ===== rtl/imge_pkg.sv =====
// ----------------------------------------------------------------------------
// imge_pkg
// shared types and constants of the incidence matrix graph engine
// ----------------------------------------------------------------------------
package imge_pkg;

    localparam int FUNC_W     = 2;
    localparam int VTX_W      = 6;
    localparam int EDGE_IDX_W = 9;
    localparam int VALUE_W    = 10;
    localparam int VCNT_W     = 7;
    localparam int ECNT_W     = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // request kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_DEGREE = 2'd1,
        FUNC_ADJ    = 2'd2,
        FUNC_LIST   = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_EDGE_COUNT   = 1'b1
    } t_cfg_idx;

    // kind of result loaded into the output register
    typedef enum logic [2:0] {
        RES_ERR,
        RES_ADD,
        RES_DEGREE,
        RES_ADJ,
        RES_EMPTY,
        RES_NEIGHBOUR
    } t_res;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ADD_WR,
        S_SCAN,
        S_DRAIN,
        S_MASK,
        S_CHECK,
        S_EMIT,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic add_read;
        logic add_write;
        logic scan_start;
        logic scan_step;
        logic mask_reach;
        logic emit_start;
        logic emit_step;
        logic out_load;
        t_res res_kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic  clr_done;
        logic  err;
        t_func func;
        logic  scan_empty;
        logic  scan_last;
        logic  reach_zero;
        logic  bit_set;
        logic  emit_last;
        logic  out_free;
    } t_stat;

endpackage

// ===== rtl/incidence_matrix_graph_engine.sv =====
// ----------------------------------------------------------------------------
// incidence_matrix_graph_engine
// vertex-by-edge incidence bit matrix with add edge, degree, adjacency
// test and neighbour listing requests
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall with func, vertex_a, vertex_b and
//   edge_index; a request is taken when valid is high and stall is low
//   output channel: o_out_valid / i_out_stall with status, value, found, last;
//   one result per request, except neighbour listing, which gives one result
//   per neighbour in ascending order with last on the final one
//   config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 is
//   vertex_count and index 1 is edge_count; write only while idle
// timing
//   one request at a time; degree, adjacency and listing read one edge column
//   a cycle from the matrix memory, for each of the ne live edges; listing
//   then walks the vertex slots up to the last neighbour, below MAX_VERTICES,
//   and waits on the receiver before loading each neighbour result
// reset
//   the memory is swept to zero column by column; requests stall meanwhile
// stall
//   a result waits in the output register while i_out_stall is high; the
//   walk pauses with it, so no result is lost or repeated
// ----------------------------------------------------------------------------
module incidence_matrix_graph_engine
    import imge_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [VTX_W-1:0]      i_vertex_a,
    input  logic [VTX_W-1:0]      i_vertex_b,
    input  logic [EDGE_IDX_W-1:0] i_edge_index,

    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_status,
    output logic [VALUE_W-1:0]    o_value,
    output logic                  o_found,
    output logic                  o_last,

    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: owns the state and drives the request stall
    imge_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // matrix memory, counters, accumulators and the output register
    imge_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_vertex_a   (i_vertex_a),
        .i_vertex_b   (i_vertex_b),
        .i_edge_index (i_edge_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_found      (o_found),
        .o_last       (o_last)
    );

endmodule

// ===== rtl/imge_dp.sv =====
// ----------------------------------------------------------------------------
// imge_dp
// datapath: config registers, incidence memory, scan accumulators,
// neighbour walk and output register
// ----------------------------------------------------------------------------
module imge_dp
    import imge_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [VTX_W-1:0]      i_vertex_a,
    input  logic [VTX_W-1:0]      i_vertex_b,
    input  logic [EDGE_IDX_W-1:0] i_edge_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_status,
    output logic [VALUE_W-1:0]    o_value,
    output logic                  o_found,
    output logic                  o_last
);

    localparam int AW  = $clog2(MAX_EDGES);
    localparam int SW0 = $clog2(MAX_EDGES + 1);
    localparam int NEW = (ECNT_W > SW0) ? ECNT_W : SW0;
    localparam int VIW = $clog2(MAX_VERTICES);

    // configuration
    logic [VCNT_W-1:0] r_vertex_count;
    logic [ECNT_W-1:0] r_edge_count;

    // latched request
    t_func                 r_func;
    logic [VTX_W-1:0]      r_va;
    logic [VTX_W-1:0]      r_vb;
    logic [EDGE_IDX_W-1:0] r_ei;

    // memory, one word per edge column
    logic [MAX_VERTICES-1:0] mem [MAX_EDGES];
    logic [MAX_VERTICES-1:0] r_rdata;
    logic                    r_rd_valid;

    logic [AW-1:0]           r_clr_cnt;
    logic [NEW-1:0]          r_scan_cnt;
    logic [VALUE_W-1:0]      r_deg;
    logic                    r_adj;
    logic [MAX_VERTICES-1:0] r_reach;
    logic [VIW-1:0]          r_v;

    logic                    r_out_valid;
    logic                    r_status;
    logic [VALUE_W-1:0]      r_value;
    logic                    r_found;
    logic                    r_last;

    logic [VCNT_W-1:0]       nv;
    logic [NEW-1:0]          ecnt_ext;
    logic [NEW-1:0]          ne;
    logic [MAX_VERTICES-1:0] abit;
    logic [MAX_VERTICES-1:0] bbit;
    logic [MAX_VERTICES-1:0] live_mask;
    logic [MAX_VERTICES-1:0] vbit;
    logic                    va_bad;
    logic                    vb_bad;
    logic                    ei_bad;
    logic                    hit_a;
    logic                    hit_b;
    logic                    emit_last;
    logic                    out_free;
    logic [AW-1:0]           add_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [MAX_VERTICES-1:0] wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;

    // live counts, clamped to the build maxima
    assign nv = (r_vertex_count > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                        : r_vertex_count;
    assign ecnt_ext = NEW'(r_edge_count);
    assign ne = (ecnt_ext > NEW'(MAX_EDGES)) ? NEW'(MAX_EDGES) : ecnt_ext;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            abit[i]      = (r_va == VTX_W'(i));
            bbit[i]      = (r_vb == VTX_W'(i));
            live_mask[i] = (VCNT_W'(i) < nv);
            vbit[i]      = (r_v == VIW'(i));
        end
    end

    assign va_bad = ({1'b0, r_va} >= nv);
    assign vb_bad = ({1'b0, r_vb} >= nv);
    assign ei_bad = (NEW'(r_ei) >= ne);

    assign hit_a     = |(r_rdata & abit);
    assign hit_b     = |(r_rdata & bbit);
    assign emit_last = ((r_reach & ~vbit) == '0);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign add_addr  = AW'(r_ei);

    always_comb begin
        o_stat.clr_done   = (r_clr_cnt == AW'(MAX_EDGES - 1));
        o_stat.err        = va_bad
                          || (((r_func == FUNC_ADD) || (r_func == FUNC_ADJ)) && vb_bad)
                          || ((r_func == FUNC_ADD) && ei_bad);
        o_stat.func       = r_func;
        o_stat.scan_empty = (ne == '0);
        o_stat.scan_last  = (r_scan_cnt == ne - 1'b1);
        o_stat.reach_zero = (r_reach == '0);
        o_stat.bit_set    = r_reach[r_v];
        o_stat.emit_last  = emit_last;
        o_stat.out_free   = out_free;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_edge_count   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[VCNT_W-1:0];
                CFG_EDGE_COUNT:   r_edge_count   <= i_cfg_data[ECNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= t_func'(i_func);
            r_va   <= i_vertex_a;
            r_vb   <= i_vertex_b;
            r_ei   <= i_edge_index;
        end
    end

    // memory ports
    assign wr_en   = i_cmd.clr_step || i_cmd.add_write;
    assign wr_addr = i_cmd.clr_step ? r_clr_cnt : add_addr;
    assign wr_data = i_cmd.clr_step ? '0 : (r_rdata | abit | bbit);
    assign rd_en   = i_cmd.add_read || i_cmd.scan_step;
    assign rd_addr = i_cmd.add_read ? add_addr : r_scan_cnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_scan_cnt <= '0;
            r_rd_valid <= 1'b0;
            r_v        <= '0;
        end else begin
            r_rd_valid <= i_cmd.scan_step;
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan_cnt <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
            if (i_cmd.emit_start) begin
                r_v <= '0;
            end else if (i_cmd.emit_step) begin
                r_v <= r_v + 1'b1;
            end
        end
    end

    // scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_deg   <= '0;
            r_adj   <= 1'b0;
            r_reach <= '0;
        end else if (r_rd_valid) begin
            if (hit_a && (r_deg != '1)) begin
                r_deg <= r_deg + 1'b1;
            end
            if (hit_a && hit_b) begin
                r_adj <= 1'b1;
            end
            if (hit_a) begin
                r_reach <= r_reach | r_rdata;
            end
        end else if (i_cmd.mask_reach) begin
            r_reach <= r_reach & live_mask & ~abit;
        end else if (i_cmd.emit_step && i_cmd.out_load) begin
            r_reach <= r_reach & ~vbit;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.res_kind)
                RES_ERR: begin
                    r_status <= 1'b1;
                    r_value  <= '0;
                    r_found  <= 1'b0;
                    r_last   <= 1'b1;
                end
                RES_DEGREE: begin
                    r_status <= 1'b0;
                    r_value  <= r_deg;
                    r_found  <= 1'b1;
                    r_last   <= 1'b1;
                end
                RES_ADJ: begin
                    r_status <= 1'b0;
                    r_value  <= VALUE_W'(r_adj);
                    r_found  <= 1'b1;
                    r_last   <= 1'b1;
                end
                RES_NEIGHBOUR: begin
                    r_status <= 1'b0;
                    r_value  <= VALUE_W'(r_v);
                    r_found  <= 1'b1;
                    r_last   <= emit_last;
                end
                default: begin
                    r_status <= 1'b0;
                    r_value  <= '0;
                    r_found  <= 1'b0;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_found     = r_found;
    assign o_last      = r_last;

endmodule

// ===== rtl/imge_ctrl.sv =====
// ----------------------------------------------------------------------------
// imge_ctrl
// request sequencer: clearing pass, decode, column scan, neighbour walk
// ----------------------------------------------------------------------------
module imge_ctrl
    import imge_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.err)                      n_state = S_RESULT;
                else if (i_stat.func == FUNC_ADD)    n_state = S_ADD_WR;
                else if (i_stat.scan_empty)          n_state = S_DRAIN;
                else                                 n_state = S_SCAN;
            end
            S_ADD_WR: n_state = S_RESULT;
            S_SCAN: begin
                if (i_stat.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = (i_stat.func == FUNC_LIST) ? S_MASK : S_RESULT;
            end
            S_MASK:  n_state = S_CHECK;
            S_CHECK: begin
                n_state = i_stat.reach_zero ? S_RESULT : S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.bit_set && i_stat.out_free && i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.res_kind = RES_EMPTY;
        o_in_stall     = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE:  o_cmd.load_in  = i_in_valid;
            S_DECODE: begin
                o_cmd.add_read   = !i_stat.err && (i_stat.func == FUNC_ADD);
                o_cmd.scan_start = 1'b1;
            end
            S_ADD_WR: o_cmd.add_write = 1'b1;
            S_SCAN:   o_cmd.scan_step = 1'b1;
            S_DRAIN:  ;
            S_MASK:   o_cmd.mask_reach = 1'b1;
            S_CHECK:  o_cmd.emit_start = 1'b1;
            S_EMIT: begin
                if (!i_stat.bit_set) begin
                    o_cmd.emit_step = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_step = 1'b1;
                    o_cmd.out_load  = 1'b1;
                    o_cmd.res_kind  = RES_NEIGHBOUR;
                end
            end
            S_RESULT: begin
                o_cmd.out_load = i_stat.out_free;
                priority if (i_stat.err)                o_cmd.res_kind = RES_ERR;
                else if (i_stat.func == FUNC_ADD)       o_cmd.res_kind = RES_ADD;
                else if (i_stat.func == FUNC_DEGREE)    o_cmd.res_kind = RES_DEGREE;
                else if (i_stat.func == FUNC_ADJ)       o_cmd.res_kind = RES_ADJ;
                else                                    o_cmd.res_kind = RES_EMPTY;
            end
            default: ;
        endcase
    end

endmodule
